// ===== sv/lcfs_pkg.sv =====
package lcfs_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned SIZE_W = 32;

  localparam logic CMD_ARRIVE   = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } lcfs_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHARGE,
    ST_PUSH,
    ST_LOAD,
    ST_EMIT
  } lcfs_state_e;

  typedef struct packed {
    logic capture;
    logic calc_elapsed;
    logic charge;
    logic push;
    logic pop;
    logic load_top;
    logic set_full;
    logic set_empty;
    logic emit;
  } lcfs_ctl_t;

  typedef struct packed {
    logic is_complete;
    logic stack_empty;
    logic stack_full;
    logic one_left;
    logic out_free;
  } lcfs_sts_t;

  function automatic logic [TIME_W-1:0] sat_finish(logic [TIME_W-1:0] t,
                                                   logic [SIZE_W-1:0] len);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + {{(TIME_W + 1 - SIZE_W){1'b0}}, len};
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

endpackage

// ===== sv/lcfs_ram.sv =====
module lcfs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lcfs_ctrl.sv =====
module lcfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  lcfs_pkg::lcfs_sts_t sts_i,
  output lcfs_pkg::lcfs_ctl_t ctl_o
);
  import lcfs_pkg::*;

  lcfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!sts_i.is_complete) begin
          if (sts_i.stack_full) state_d = ST_EMIT;
          else if (sts_i.stack_empty) state_d = ST_PUSH;
          else state_d = ST_CHARGE;
        end else begin
          if (sts_i.stack_empty || sts_i.one_left) state_d = ST_EMIT;
          else state_d = ST_LOAD;
        end
      end
      ST_CHARGE: state_d = ST_PUSH;
      ST_PUSH:   state_d = ST_EMIT;
      ST_LOAD:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        ctl_o.capture = s_tvalid_i;
      end
      ST_DECODE: begin
        if (!sts_i.is_complete) begin
          ctl_o.set_full     = sts_i.stack_full;
          ctl_o.calc_elapsed = !sts_i.stack_full && !sts_i.stack_empty;
        end else begin
          ctl_o.set_empty = sts_i.stack_empty;
          ctl_o.pop       = !sts_i.stack_empty;
        end
      end
      ST_CHARGE: ctl_o.charge   = 1'b1;
      ST_PUSH:   ctl_o.push     = 1'b1;
      ST_LOAD:   ctl_o.load_top = 1'b1;
      ST_EMIT:   ctl_o.emit     = sts_i.out_free;
      default: begin
        ctl_o      = '0;
        s_tready_o = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_after_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> $past(state_q) == ST_DECODE)
    else $error("restart load not preceded by decode");

  a_charge_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.charge |=> ctl_o.push)
    else $error("preempted job charged without a push");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctl_o.charge, ctl_o.push, ctl_o.pop, ctl_o.load_top}) <= 1)
    else $error("more than one stack action in a cycle");
`endif

endmodule

// ===== sv/lcfs_dpath.sv =====
module lcfs_dpath #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned ID_BITS = 16,
  localparam int unsigned InRaw = lcfs_pkg::TIME_W + ID_BITS + lcfs_pkg::SIZE_W,
  localparam int unsigned InW = ((InRaw + 7) / 8) * 8,
  localparam int unsigned OutRaw = 5 + 2 * ID_BITS + lcfs_pkg::TIME_W,
  localparam int unsigned OutW = ((OutRaw + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [InW-1:0]    s_tdata_i,
  input  logic              s_tuser_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [OutW-1:0]   m_tdata_o,
  input  lcfs_pkg::lcfs_ctl_t ctl_i,
  output lcfs_pkg::lcfs_sts_t sts_o
);
  import lcfs_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned MemW = ID_BITS + SIZE_W;

  logic                in_cmd_q;
  logic [TIME_W-1:0]   in_time_q;
  logic [ID_BITS-1:0]  in_id_q;
  logic [SIZE_W-1:0]   in_size_q;

  logic [CntW-1:0]     count_q, count_d;
  logic [TIME_W-1:0]   start_time_q, start_time_d;
  logic [ID_BITS-1:0]  top_id_q, top_id_d;
  logic [SIZE_W-1:0]   top_rem_q, top_rem_d;
  logic [TIME_W-1:0]   elapsed_q;

  logic                res_cancel_q;
  logic                res_done_v_q;
  logic [ID_BITS-1:0]  res_done_id_q;
  logic                res_start_v_q;
  logic [ID_BITS-1:0]  res_start_id_q;
  logic [TIME_W-1:0]   res_finish_q;
  lcfs_status_e        res_status_q;

  logic                out_valid_q;
  logic [OutW-1:0]     out_data_q;
  logic [OutRaw-1:0]   out_raw;

  logic [CntW-1:0]     cnt_m1, cnt_m2;
  logic [SIZE_W-1:0]   charged;
  logic [MemW-1:0]     ram_rdata;
  logic [ID_BITS-1:0]  ram_id;
  logic [SIZE_W-1:0]   ram_rem;

  assign cnt_m1  = count_q - CntW'(1);
  assign cnt_m2  = count_q - CntW'(2);
  assign ram_id  = ram_rdata[SIZE_W +: ID_BITS];
  assign ram_rem = ram_rdata[SIZE_W-1:0];
  assign charged = ((elapsed_q[TIME_W-1:SIZE_W] != '0) ||
                    (elapsed_q[SIZE_W-1:0] >= top_rem_q)) ? '0 :
                   top_rem_q - elapsed_q[SIZE_W-1:0];

  lcfs_ram #(
    .WIDTH(MemW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ctl_i.charge),
    .waddr_i(cnt_m1[AW-1:0]),
    .wdata_i({top_id_q, charged}),
    .re_i   (ctl_i.pop),
    .raddr_i(cnt_m2[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    count_d      = count_q;
    start_time_d = start_time_q;
    top_id_d     = top_id_q;
    top_rem_d    = top_rem_q;
    if (ctl_i.push) begin
      count_d      = count_q + CntW'(1);
      start_time_d = in_time_q;
      top_id_d     = in_id_q;
      top_rem_d    = in_size_q;
    end else if (ctl_i.pop) begin
      count_d = cnt_m1;
    end else if (ctl_i.load_top) begin
      start_time_d = in_time_q;
      top_id_d     = ram_id;
      top_rem_d    = ram_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      start_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      start_time_q <= start_time_d;
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_id_q  <= top_id_d;
    top_rem_q <= top_rem_d;
    if (ctl_i.capture) begin
      in_cmd_q       <= s_tuser_i;
      in_time_q      <= s_tdata_i[TIME_W-1:0];
      in_id_q        <= s_tdata_i[TIME_W +: ID_BITS];
      in_size_q      <= s_tdata_i[TIME_W + ID_BITS +: SIZE_W];
      res_cancel_q   <= 1'b0;
      res_done_v_q   <= 1'b0;
      res_done_id_q  <= '0;
      res_start_v_q  <= 1'b0;
      res_start_id_q <= '0;
      res_finish_q   <= '0;
      res_status_q   <= STATUS_OK;
    end
    if (ctl_i.calc_elapsed) begin
      elapsed_q <= (in_time_q >= start_time_q) ? in_time_q - start_time_q : '0;
    end
    if (ctl_i.charge) begin
      res_cancel_q <= 1'b1;
    end
    if (ctl_i.push) begin
      res_start_v_q  <= 1'b1;
      res_start_id_q <= in_id_q;
      res_finish_q   <= sat_finish(in_time_q, in_size_q);
    end
    if (ctl_i.pop) begin
      res_done_v_q  <= 1'b1;
      res_done_id_q <= top_id_q;
    end
    if (ctl_i.load_top) begin
      res_start_v_q  <= 1'b1;
      res_start_id_q <= ram_id;
      res_finish_q   <= sat_finish(in_time_q, ram_rem);
    end
    if (ctl_i.set_full) begin
      res_status_q <= STATUS_FULL;
    end
    if (ctl_i.set_empty) begin
      res_status_q <= STATUS_EMPTY;
    end
    if (ctl_i.emit) begin
      out_data_q <= OutW'(out_raw);
    end
  end

  assign out_raw = {res_status_q, res_finish_q, res_start_id_q, res_start_v_q,
                    res_done_id_q, res_done_v_q, res_cancel_q};

  assign sts_o.is_complete = (in_cmd_q == CMD_COMPLETE);
  assign sts_o.stack_empty = (count_q == '0);
  assign sts_o.stack_full  = (count_q == CntW'(STACK_DEPTH));
  assign sts_o.one_left    = (count_q == CntW'(1));
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow the stack by one");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> (!out_valid_q || m_tready_i))
    else $error("pending result overwritten");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> count_q != '0)
    else $error("pop from an empty stack");
`endif

endmodule

// ===== sv/preemptive_lcfs_job_scheduler.sv =====
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid/tready/tdata/tuser     one event word per handshake
// m_axis    out  tvalid/tready/tdata           one result word per event word
//
// An input word is taken only while the controller is idle; the result goes to
// an output register, so the next word is accepted while a result still waits.
// After decode, a refused arrival or a completion that leaves or finds the stack
// empty goes straight to emit; an arrival on an empty stack passes the push,
// a completion with a restart the load of the new top from the registered read,
// and an arrival that preempts the charge write and then the push; its result
// becomes valid in the cycle in which the next word can be taken.
// A stalled m_axis_tready_i holds the next result in its last state, and with
// it every acceptance after that one.
// Reset clears the stack count and start time at once; the RAM is not cleared.
module preemptive_lcfs_job_scheduler #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned ID_BITS = 16,
  localparam int unsigned InRaw = 48 + ID_BITS + 32,
  localparam int unsigned InW = ((InRaw + 7) / 8) * 8,
  localparam int unsigned OutRaw = 5 + 2 * ID_BITS + 48,
  localparam int unsigned OutW = ((OutRaw + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // current_time, job_id, job_size, zero fill
  input  logic [InW-1:0]  s_axis_tdata_i,
  // command
  input  logic            s_axis_tuser_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // cancel_previous, done_valid, done_id, start_valid, start_id, finish_time,
  // status, zero fill
  output logic [OutW-1:0] m_axis_tdata_o
);
  import lcfs_pkg::*;

  lcfs_ctl_t ctl;
  lcfs_sts_t sts;

  lcfs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_o(s_axis_tready_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  lcfs_dpath #(
    .STACK_DEPTH(STACK_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o),
    .ctl_i     (ctl),
    .sts_o     (sts)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lcfs_pkg::*;

  localparam int unsigned STACK_SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic        cmd;
    logic [47:0] now;
    logic [15:0] id;
    logic [31:0] size;
  } sched_event_t;

  typedef struct packed {
    logic         cancel;
    logic         done_v;
    logic [15:0]  done_id;
    logic         start_v;
    logic [15:0]  start_id;
    logic [47:0]  finish;
    lcfs_status_e status;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // current_time, job_id, job_size
  logic [95:0] s_axis_tdata_i = '0;
  // command
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // cancel_previous, done_valid, done_id, start_valid, start_id, finish_time, status
  logic [87:0] m_axis_tdata_o;

  preemptive_lcfs_job_scheduler #(
    .STACK_DEPTH(STACK_SLOTS),
    .ID_BITS(16)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  sched_event_t  event_q[$];
  sched_result_t schedule_q[$];

  logic [15:0] job_id_stk[STACK_SLOTS];
  logic [31:0] job_left_stk[STACK_SLOTS];
  int unsigned jobs_held = 0;
  logic [47:0] run_since = '0;

  int unsigned n_arrive = 0, n_preempt = 0, n_refused = 0;
  int unsigned n_complete = 0, n_idle_complete = 0, n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned words_taken = 0;
  int unsigned cycle_cnt = 0;
  logic        quiet = 1'b0;
  logic [47:0] sim_now = '0;

  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  function automatic logic [47:0] finish_sat(logic [47:0] t, logic [31:0] len);
    logic [48:0] sum;
    sum = {1'b0, t} + {17'b0, len};
    return sum[48] ? '1 : sum[47:0];
  endfunction

  function automatic sched_result_t schedule_event(sched_event_t ev);
    sched_result_t r;
    logic [47:0]   elapsed;
    logic [31:0]   left;
    r = '0;
    r.status = STATUS_OK;
    if (ev.cmd == CMD_ARRIVE) begin
      n_arrive++;
      if (jobs_held >= STACK_SLOTS) begin
        r.status = STATUS_FULL;
        n_refused++;
      end else begin
        if (jobs_held > 0) begin
          elapsed = (ev.now >= run_since) ? ev.now - run_since : '0;
          left = job_left_stk[jobs_held - 1];
          job_left_stk[jobs_held - 1] = ({16'b0, left} > elapsed) ? left - elapsed[31:0] : '0;
          r.cancel = 1'b1;
          n_preempt++;
        end
        job_id_stk[jobs_held] = ev.id;
        job_left_stk[jobs_held] = ev.size;
        jobs_held++;
        run_since = ev.now;
        r.start_v = 1'b1;
        r.start_id = ev.id;
        r.finish = finish_sat(ev.now, ev.size);
      end
    end else begin
      n_complete++;
      if (jobs_held == 0) begin
        r.status = STATUS_EMPTY;
        n_idle_complete++;
      end else begin
        jobs_held--;
        r.done_v = 1'b1;
        r.done_id = job_id_stk[jobs_held];
        if (jobs_held > 0) begin
          run_since = ev.now;
          r.start_v = 1'b1;
          r.start_id = job_id_stk[jobs_held - 1];
          r.finish = finish_sat(ev.now, job_left_stk[jobs_held - 1]);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  task automatic add_event(logic cmd, logic [47:0] t, logic [15:0] id, logic [31:0] size);
    sched_event_t ev;
    ev.cmd = cmd;
    ev.now = t;
    ev.id = id;
    ev.size = size;
    event_q.push_back(ev);
  endtask

  task automatic advance_time();
    case ($urandom_range(0, 19))
      0, 1, 2:  sim_now = sim_now;
      3:        sim_now = 48'({$urandom, $urandom});
      4, 5:     sim_now = sim_now + $urandom;
      default:  sim_now = sim_now + $urandom_range(1, 60);
    endcase
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  task automatic add_random(logic cmd);
    advance_time();
    add_event(cmd, sim_now, 16'($urandom), pick_size());
  endtask

  task automatic wait_drained();
    while (event_q.size() != 0 || s_axis_tvalid_i || schedule_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("preemptive_lcfs_job_scheduler regression: fail");
      $finish;
    end
  end

  // Sender: holds a word until taken, otherwise idles in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    sched_event_t nxt;
    sched_event_t seen;
    logic         give;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      s_axis_tuser_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        seen.cmd = s_axis_tuser_i;
        {seen.size, seen.id, seen.now} = s_axis_tdata_i;
        schedule_q.push_back(schedule_event(seen));
        words_taken <= words_taken + 1;
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        give = 1'b0;
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (event_q.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            tx_gap <= $urandom_range(0, 11);
          end else begin
            nxt = event_q.pop_front();
            give = 1'b1;
            s_axis_tdata_i <= {nxt.size, nxt.id, nxt.now};
            s_axis_tuser_i <= nxt.cmd;
          end
        end
        s_axis_tvalid_i <= give;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is flowing.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!hold_done && words_taken >= 60) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 11);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (schedule_q.size() == 0) begin
        $error("result word 0x%0h arrived with nothing expected", m_axis_tdata_o);
        n_fail++;
      end else begin
        want = schedule_q.pop_front();
        n_checked++;
        check_field("cancel_previous", 48'(want.cancel), 48'(m_axis_tdata_o[0]));
        check_field("done_valid", 48'(want.done_v), 48'(m_axis_tdata_o[1]));
        check_field("done_id", 48'(want.done_id), 48'(m_axis_tdata_o[17:2]));
        check_field("start_valid", 48'(want.start_v), 48'(m_axis_tdata_o[18]));
        check_field("start_id", 48'(want.start_id), 48'(m_axis_tdata_o[34:19]));
        check_field("finish_time", want.finish, m_axis_tdata_o[82:35]);
        check_field("status", 48'(want.status), 48'(m_axis_tdata_o[84:83]));
      end
    end
  end

  initial begin
    int unsigned seg_len;
    int unsigned arrive_pct;
    int unsigned made;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty completions, extremes, saturation, time going backwards.
    add_event(CMD_COMPLETE, 48'd0, 16'h0, 32'h0);
    add_event(CMD_ARRIVE, 48'd0, 16'h0000, 32'h0);
    add_event(CMD_ARRIVE, 48'd0, 16'hFFFF, 32'hFFFF_FFFF);
    add_event(CMD_ARRIVE, 48'd10, 16'h1234, 32'd100);
    add_event(CMD_ARRIVE, 48'd5, 16'h0005, 32'd50);
    add_event(CMD_ARRIVE, 48'd1000, 16'h0006, 32'd20);
    add_event(CMD_COMPLETE, 48'd1000, 16'hFFFF, 32'hFFFF_FFFF);
    add_event(CMD_COMPLETE, 48'd1001, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, 48'd1001, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, 48'd2000, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, 48'd2000, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, 48'd2001, 16'h0, 32'h0);
    add_event(CMD_ARRIVE, '1, 16'hAAAA, 32'hFFFF_FFFF);
    add_event(CMD_ARRIVE, 48'hFFFF_FFFF_FFF5, 16'h5555, 32'd5);
    add_event(CMD_ARRIVE, '1, 16'h5A5A, 32'h5555_5555);
    add_event(CMD_COMPLETE, '1, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, '1, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, '1, 16'h0, 32'h0);
    add_event(CMD_COMPLETE, '1, 16'h0, 32'h0);
    wait_drained();

    // Overfill the stack, then drain it past empty; the long receiver hold lands here.
    sim_now = '0;
    repeat (STACK_SLOTS + 6) add_random(CMD_ARRIVE);
    repeat (STACK_SLOTS + 8) add_random(CMD_COMPLETE);
    wait_drained();

    made = 0;
    while (made < 330) begin
      seg_len = $urandom_range(5, 40);
      case ($urandom_range(0, 4))
        0:       arrive_pct = 20;
        1:       arrive_pct = 40;
        2:       arrive_pct = 50;
        3:       arrive_pct = 60;
        default: arrive_pct = 85;
      endcase
      repeat (seg_len) begin
        add_random(($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_COMPLETE);
      end
      made += seg_len;
    end
    wait_drained();

    quiet = 1'b1;
    repeat (60) add_random($urandom_range(0, 1) ? CMD_ARRIVE : CMD_COMPLETE);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results: %0d arrivals (%0d preempting, %0d refused when full),",
             n_checked, n_arrive, n_preempt, n_refused);
    $display("and %0d completions (%0d with no job running).", n_complete, n_idle_complete);
    if (n_fail == 0 && schedule_q.size() == 0) begin
      $display("preemptive_lcfs_job_scheduler regression: pass");
    end else begin
      $display("preemptive_lcfs_job_scheduler regression: fail");
    end
    $finish;
  end

endmodule
